// ----- sv/skt_pkg.sv -----
// shared constants and the entry type of the sorted key table
package skt_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    // fixed port widths
    localparam int MODE_W   = 1;
    localparam int KEY_W    = 16;
    localparam int PAY_W    = 32;
    localparam int LEN_W    = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(4);

    localparam logic [MODE_W-1:0] MODE_ADD = 1'b0;
    localparam logic [MODE_W-1:0] MODE_GET = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [LEN_W-1:0]        len;
        logic                    mark;
    } entry_t;

endpackage

// ----- sv/sorted_key_table.sv -----
// sorted key table: binary search over an entry memory with shift-up insert
// a request is captured in IDLE, probed by binary search in LOOK (up to log2(depth)+1
// probes) and answered in DECIDE; an insert below the top entry first moves entries up in SHIFT
// throughput: one item at a time; a result may wait in the output register
// while the next item is taken and searched
// reset: entry count cleared to zero, memory contents left undefined
module sorted_key_table
    import skt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [KEY_W-1:0]    key,
    input  logic [PAY_W-1:0]    payload,
    input  logic [LEN_W-1:0]    payload_len,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot,
    output logic [PAY_W-1:0]    value_out,
    output logic [LEN_W-1:0]    value_len,
    output logic                first_fetch
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // entry memory
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data <= mem[rd_addr];
    end

    // control registers
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    entry_t                  hit_reg, hit_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [PAY_W-1:0]        value_reg, value_next;
    logic [LEN_W-1:0]        vlen_reg, vlen_next;
    logic                    first_reg, first_next;

    logic             out_free;
    entry_t           new_entry;
    logic [CNT_W-1:0] lo2, hi2;
    logic [CNT_W:0]   sum_init, sum2;
    logic [CNT_W-1:0] idx_m1, idx_m2, cnt_m1;

    assign out_free  = !out_valid_reg || out_ready;
    assign new_entry = '{key: key_reg, payload: pay_reg, len: len_reg, mark: 1'b0};
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign idx_m2    = idx_reg - CNT_W'(2);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign sum_init  = {1'b0, count_reg};
    assign sum2      = {1'b0, lo2} + {1'b0, hi2};

    // narrowing of the search window from the probed key
    always_comb
    begin
        lo2 = lo_reg;
        hi2 = hi_reg;
        if (key_reg < rd_data.key)
        begin
            hi2 = mid_reg;
        end
        else
        begin
            lo2 = mid_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mode_next      = mode_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        len_next       = len_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        vlen_next      = vlen_reg;
        first_next     = first_reg;
        rd_addr        = mid_reg[IDX_W-1:0];
        we             = 1'b0;
        wa             = pos_reg[IDX_W-1:0];
        wd             = new_entry;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    key_next  = KEY_BITS'(key);
                    pay_next  = PAYLOAD_BITS'(payload);
                    len_next  = (payload_len > MAX_LEN) ? MAX_LEN : payload_len;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (count_reg == '0)
                    begin
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        mid_next   = sum_init[CNT_W:1];
                        rd_addr    = sum_init[IDX_W:1];
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_LOOK:
            begin
                if (key_reg == rd_data.key)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    hit_next   = rd_data;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    lo_next = lo2;
                    hi_next = hi2;
                    if (lo2 < hi2)
                    begin
                        mid_next = sum2[CNT_W:1];
                        rd_addr  = sum2[IDX_W:1];
                    end
                    else
                    begin
                        found_next = 1'b0;
                        pos_next   = lo2;
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (out_free)
                begin
                    status_next = STATUS_OK;
                    slot_next   = SLOT_W'(pos_reg);
                    value_next  = '0;
                    vlen_next   = '0;
                    first_next  = 1'b0;
                    state_next  = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_GET)
                    begin
                        if (found_reg)
                        begin
                            we         = 1'b1;
                            wd         = hit_reg;
                            wd.mark    = 1'b1;
                            value_next = PAY_W'(hit_reg.payload);
                            vlen_next  = hit_reg.len;
                            first_next = !hit_reg.mark;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                            slot_next   = '0;
                        end
                    end
                    else if (found_reg)
                    begin
                        // replace keeps the stored mark
                        we      = 1'b1;
                        wd      = new_entry;
                        wd.mark = hit_reg.mark;
                    end
                    else if (count_reg == DEPTH_CNT)
                    begin
                        status_next = STATUS_FULL;
                        slot_next   = '0;
                    end
                    else if (count_reg > pos_reg)
                    begin
                        // entries at and above the slot move up first
                        out_valid_next = out_valid_reg && !out_ready;
                        idx_next       = count_reg;
                        rd_addr        = cnt_m1[IDX_W-1:0];
                        state_next     = ST_SHIFT;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            ST_SHIFT:
            begin
                we = 1'b1;
                wa = idx_reg[IDX_W-1:0];
                wd = rd_data;
                if (idx_m1 > pos_reg)
                begin
                    rd_addr  = idx_m2[IDX_W-1:0];
                    idx_next = idx_m1;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                if (out_free)
                begin
                    we             = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    status_next    = STATUS_OK;
                    slot_next      = SLOT_W'(pos_reg);
                    value_next     = '0;
                    vlen_next      = '0;
                    first_next     = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        len_reg    <= len_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        vlen_reg   <= vlen_next;
        first_reg  <= first_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign value_out   = value_reg;
    assign value_len   = vlen_reg;
    assign first_fetch = first_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count moved by other than one");

    a_look_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> lo_reg < hi_reg && mid_reg < count_reg)
        else $error("search probe outside the live window");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == ST_DECIDE || state_reg == ST_SHIFT || state_reg == ST_INSERT)
        else $error("memory write outside an update state");

    a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> idx_reg > pos_reg && idx_reg <= count_reg)
        else $error("shift destination outside the moved range");

endmodule
